// File: src/dllp_pkg.sv
// ----------------------------------------------------------------------------
// dllp_pkg: shared definitions for the linked-list node pool
// Pool sizing, command and status codes, controller states and the node
// record that the node store keeps.
// ----------------------------------------------------------------------------
package dllp_pkg;

    localparam int POOL_DEPTH = 64;
    localparam int PTR_W      = $clog2(POOL_DEPTH);
    localparam int LINK_W     = PTR_W + 1;
    localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
    localparam int DATA_W     = 32;
    localparam int CMD_W      = 3;
    localparam int STATUS_W   = 2;

    // A link equal to the pool depth marks the end of the chain.
    localparam logic [LINK_W-1:0] NIL = LINK_W'(POOL_DEPTH);

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_REMOVE     = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_EMPTY      = 2'd1,
        ST_FULL       = 2'd2,
        ST_BAD_HANDLE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PUSH,
        S_UNLINK,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [LINK_W-1:0]        prev;
        logic [LINK_W-1:0]        next;
    } node_t;

    typedef struct packed {
        logic              en_value;
        logic              en_prev;
        logic              en_next;
        logic [PTR_W-1:0]  addr;
        node_t             data;
    } node_wr_t;

endpackage

// File: src/dllp_req_if.sv
// ----------------------------------------------------------------------------
// dllp_req_if: command channel of the linked-list node pool
// Valid/ready channel carrying one command item.
// ----------------------------------------------------------------------------
interface dllp_req_if import dllp_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] value;
    logic [PTR_W-1:0]         node_handle;

    modport source (output valid, output cmd, output value, output node_handle, input ready);
    modport sink   (input valid, input cmd, input value, input node_handle, output ready);

endinterface

// File: src/dllp_rsp_if.sv
// ----------------------------------------------------------------------------
// dllp_rsp_if: result channel of the linked-list node pool
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface dllp_rsp_if import dllp_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic [PTR_W-1:0]         new_handle;
    logic signed [DATA_W-1:0] taken_value;
    logic [CNT_W-1:0]         count;

    modport source (output valid, output status, output new_handle, output taken_value,
                    output count, input ready);
    modport sink   (input valid, input status, input new_handle, input taken_value,
                    input count, output ready);

endinterface

// File: src/dllp_node_store.sv
// ----------------------------------------------------------------------------
// dllp_node_store: node memory of the pool
// One entry per node holding value, previous link and next link. Separate
// read and write addresses; each field has its own write enable; registered read.
// ----------------------------------------------------------------------------
module dllp_node_store import dllp_pkg::*;
(
    input  logic             clk,
    input  logic             rd_en,
    input  logic [PTR_W-1:0] rd_addr,
    input  node_wr_t         wr,
    output node_t            rd_data
);

    logic signed [DATA_W-1:0] value_mem [POOL_DEPTH];
    logic [LINK_W-1:0]        prev_mem  [POOL_DEPTH];
    logic [LINK_W-1:0]        next_mem  [POOL_DEPTH];
    node_t                    rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en_value)
        begin
            value_mem[wr.addr] <= wr.data.value;
        end
        if (wr.en_prev)
        begin
            prev_mem[wr.addr] <= wr.data.prev;
        end
        if (wr.en_next)
        begin
            next_mem[wr.addr] <= wr.data.next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg.value <= value_mem[rd_addr];
            rd_data_reg.prev  <= prev_mem[rd_addr];
            rd_data_reg.next  <= next_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/doubly_linked_list_pool_core.sv
// ----------------------------------------------------------------------------
// doubly_linked_list_pool_core: doubly linked list in a fixed node pool
// Push front/back, pop front/back and remove by handle, with a free stack.
// ----------------------------------------------------------------------------
// Flow: a successful push goes through the push state, a successful pop or
// remove through the unlink state, then the finishing state; a rejected or
// unknown command goes straight there; the output register then takes the
// result. One item at a time, held up while the result side stalls; the node
// memory's registered read and the second link write in S_FINISH set this.
// Reset: asynchronous, clears list and free-stack control, no clearing pass.
// ----------------------------------------------------------------------------
module doubly_linked_list_pool_core import dllp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    dllp_req_if.sink  req,
    dllp_rsp_if.source rsp
);

    // Controller state and list registers.
    state_t              state_reg,      state_next;
    logic [LINK_W-1:0]   head_reg,       head_next;
    logic [LINK_W-1:0]   tail_reg,       tail_next;
    logic [CNT_W-1:0]    count_reg,      count_next;
    logic [CNT_W-1:0]    free_top_reg,   free_top_next;
    // Lowest stack level ever reached. Stack slots below it were never
    // written and still hold their reset contents, which are computed.
    logic [CNT_W-1:0]    fill_mark_reg,  fill_mark_next;
    logic                fill_hit_reg,   fill_hit_next;
    logic [POOL_DEPTH-1:0] in_use_reg,   in_use_next;

    // Per-item working registers.
    logic signed [DATA_W-1:0] value_reg,  value_next;
    logic                push_front_reg, push_front_next;
    logic [PTR_W-1:0]    victim_reg,     victim_next;
    logic                nbr_en_reg,     nbr_en_next;
    logic                nbr_prev_reg,   nbr_prev_next;
    logic [PTR_W-1:0]    nbr_reg,        nbr_next;
    logic [LINK_W-1:0]   link_reg,       link_next;
    status_t             res_status_reg, res_status_next;
    logic [PTR_W-1:0]    res_handle_reg, res_handle_next;
    logic signed [DATA_W-1:0] res_taken_reg, res_taken_next;

    // Output stage.
    logic                rsp_valid_reg,  rsp_valid_next;
    status_t             rsp_status_reg, rsp_status_next;
    logic [PTR_W-1:0]    rsp_handle_reg, rsp_handle_next;
    logic signed [DATA_W-1:0] rsp_taken_reg, rsp_taken_next;
    logic [CNT_W-1:0]    rsp_count_reg,  rsp_count_next;

    // Memory controls.
    logic                node_rd_en;
    logic [PTR_W-1:0]    node_rd_addr;
    node_wr_t            node_wr;
    node_t               node_rd;

    logic [PTR_W-1:0]    fs_mem [POOL_DEPTH];
    logic [PTR_W-1:0]    fs_rd_reg;
    logic                fs_rd_en;
    logic                fs_wr_en;
    logic [PTR_W-1:0]    fs_addr;
    logic [PTR_W-1:0]    fs_wdata;

    // Decode helpers.
    cmd_t                req_cmd;
    logic [LINK_W-1:0]   pop_idx;
    logic [PTR_W-1:0]    new_idx;
    logic                slot_free;
    logic                emit;

    assign req_cmd   = cmd_t'(req.cmd);
    assign req.ready = (state_reg == S_IDLE);
    assign slot_free = !rsp_valid_reg || rsp.ready;
    assign pop_idx   = (req_cmd == CMD_POP_FRONT) ? head_reg : tail_reg;

    // The node handed out by a push: either the word read from the free
    // stack, or the computed reset contents of a never-written slot.
    assign new_idx = fill_hit_reg ? PTR_W'(CNT_W'(POOL_DEPTH) - free_top_reg) : fs_rd_reg;

    dllp_node_store u_node_store (
        .clk     (clk),
        .rd_en   (node_rd_en),
        .rd_addr (node_rd_addr),
        .wr      (node_wr),
        .rd_data (node_rd)
    );

    // Free stack memory, one access per cycle, registered read.
    always_ff @(posedge clk)
    begin
        if (fs_wr_en)
        begin
            fs_mem[fs_addr] <= fs_wdata;
        end
        if (fs_rd_en)
        begin
            fs_rd_reg <= fs_mem[fs_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= NIL;
            tail_reg      <= NIL;
            count_reg     <= '0;
            free_top_reg  <= CNT_W'(POOL_DEPTH);
            fill_mark_reg <= CNT_W'(POOL_DEPTH);
            in_use_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            free_top_reg  <= free_top_next;
            fill_mark_reg <= fill_mark_next;
            in_use_reg    <= in_use_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fill_hit_reg   <= fill_hit_next;
        value_reg      <= value_next;
        push_front_reg <= push_front_next;
        victim_reg     <= victim_next;
        nbr_en_reg     <= nbr_en_next;
        nbr_prev_reg   <= nbr_prev_next;
        nbr_reg        <= nbr_next;
        link_reg       <= link_next;
        res_status_reg <= res_status_next;
        res_handle_reg <= res_handle_next;
        res_taken_reg  <= res_taken_next;
        rsp_status_reg <= rsp_status_next;
        rsp_handle_reg <= rsp_handle_next;
        rsp_taken_reg  <= rsp_taken_next;
        rsp_count_reg  <= rsp_count_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        free_top_next   = free_top_reg;
        fill_mark_next  = fill_mark_reg;
        fill_hit_next   = fill_hit_reg;
        in_use_next     = in_use_reg;
        value_next      = value_reg;
        push_front_next = push_front_reg;
        victim_next     = victim_reg;
        nbr_en_next     = nbr_en_reg;
        nbr_prev_next   = nbr_prev_reg;
        nbr_next        = nbr_reg;
        link_next       = link_reg;
        res_status_next = res_status_reg;
        res_handle_next = res_handle_reg;
        res_taken_next  = res_taken_reg;

        node_rd_en   = 1'b0;
        node_rd_addr = '0;
        node_wr      = '0;
        fs_rd_en     = 1'b0;
        fs_wr_en     = 1'b0;
        fs_addr      = '0;
        fs_wdata     = victim_reg;
        emit         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    // Default result of a command that finishes without work.
                    res_status_next = ST_OK;
                    res_handle_next = '0;
                    res_taken_next  = '0;
                    nbr_en_next     = 1'b0;
                    state_next      = S_FINISH;
                    case (req_cmd) inside
                        CMD_PUSH_FRONT, CMD_PUSH_BACK:
                        begin
                            if (free_top_reg == '0)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                fs_rd_en        = 1'b1;
                                fs_addr         = PTR_W'(free_top_reg - CNT_W'(1));
                                fill_hit_next   = (free_top_reg == fill_mark_reg);
                                value_next      = req.value;
                                push_front_next = (req_cmd == CMD_PUSH_FRONT);
                                state_next      = S_PUSH;
                            end
                        end
                        CMD_POP_FRONT, CMD_POP_BACK:
                        begin
                            if (pop_idx == NIL || !in_use_reg[pop_idx[PTR_W-1:0]])
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                node_rd_en   = 1'b1;
                                node_rd_addr = pop_idx[PTR_W-1:0];
                                victim_next  = pop_idx[PTR_W-1:0];
                                state_next   = S_UNLINK;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if ({1'b0, req.node_handle} >= NIL || !in_use_reg[req.node_handle])
                            begin
                                res_status_next = ST_BAD_HANDLE;
                            end
                            else
                            begin
                                node_rd_en   = 1'b1;
                                node_rd_addr = req.node_handle;
                                victim_next  = req.node_handle;
                                state_next   = S_UNLINK;
                            end
                        end
                        default:
                        begin
                            // Unknown commands leave the list alone.
                        end
                    endcase
                end
            end

            S_PUSH:
            begin
                // Write the whole new node and pop it off the free stack.
                node_wr.en_value   = 1'b1;
                node_wr.en_prev    = 1'b1;
                node_wr.en_next    = 1'b1;
                node_wr.addr       = new_idx;
                node_wr.data.value = value_reg;
                node_wr.data.prev  = NIL;
                node_wr.data.next  = NIL;
                in_use_next[new_idx] = 1'b1;
                free_top_next      = free_top_reg - CNT_W'(1);
                if (fill_hit_reg)
                begin
                    fill_mark_next = free_top_reg - CNT_W'(1);
                end
                count_next      = count_reg + CNT_W'(1);
                res_status_next = ST_OK;
                res_handle_next = new_idx;
                res_taken_next  = '0;
                link_next       = LINK_W'(new_idx);
                if (head_reg == NIL)
                begin
                    head_next   = LINK_W'(new_idx);
                    tail_next   = LINK_W'(new_idx);
                    nbr_en_next = 1'b0;
                end
                else if (push_front_reg)
                begin
                    node_wr.data.next = head_reg;
                    nbr_en_next       = 1'b1;
                    nbr_prev_next     = 1'b1;
                    nbr_next          = head_reg[PTR_W-1:0];
                    head_next         = LINK_W'(new_idx);
                end
                else
                begin
                    node_wr.data.prev = tail_reg;
                    nbr_en_next       = 1'b1;
                    nbr_prev_next     = 1'b0;
                    nbr_next          = tail_reg[PTR_W-1:0];
                    tail_next         = LINK_W'(new_idx);
                end
                state_next = S_FINISH;
            end

            S_UNLINK:
            begin
                // The node's links are back from memory. Splice the
                // predecessor now, the successor in the finishing cycle.
                if (node_rd.prev != NIL)
                begin
                    node_wr.en_next   = 1'b1;
                    node_wr.addr      = node_rd.prev[PTR_W-1:0];
                    node_wr.data.next = node_rd.next;
                end
                else
                begin
                    head_next = node_rd.next;
                end
                if (node_rd.next != NIL)
                begin
                    nbr_en_next   = 1'b1;
                    nbr_prev_next = 1'b1;
                    nbr_next      = node_rd.next[PTR_W-1:0];
                    link_next     = node_rd.prev;
                end
                else
                begin
                    nbr_en_next = 1'b0;
                    tail_next   = node_rd.prev;
                end
                in_use_next[victim_reg] = 1'b0;
                fs_wr_en        = 1'b1;
                fs_addr         = PTR_W'(free_top_reg);
                fs_wdata        = victim_reg;
                free_top_next   = free_top_reg + CNT_W'(1);
                count_next      = count_reg - CNT_W'(1);
                res_status_next = ST_OK;
                res_handle_next = '0;
                res_taken_next  = node_rd.value;
                state_next      = S_FINISH;
            end

            S_FINISH:
            begin
                // The neighbor write repeats harmlessly while the output
                // stage is still occupied.
                if (nbr_en_reg)
                begin
                    node_wr.en_prev   = nbr_prev_reg;
                    node_wr.en_next   = !nbr_prev_reg;
                    node_wr.addr      = nbr_reg;
                    node_wr.data.prev = link_reg;
                    node_wr.data.next = link_reg;
                end
                if (slot_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output stage: holds a finished result while the next item is taken.
    always_comb
    begin
        rsp_valid_next  = rsp_valid_reg;
        rsp_status_next = rsp_status_reg;
        rsp_handle_next = rsp_handle_reg;
        rsp_taken_next  = rsp_taken_reg;
        rsp_count_next  = rsp_count_reg;
        if (emit)
        begin
            rsp_valid_next  = 1'b1;
            rsp_status_next = res_status_reg;
            rsp_handle_next = res_handle_reg;
            rsp_taken_next  = res_taken_reg;
            rsp_count_next  = count_reg;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.new_handle  = rsp_handle_reg;
    assign rsp.taken_value = rsp_taken_reg;
    assign rsp.count       = rsp_count_reg;

endmodule

// File: src/dllp_checker.sv
// ----------------------------------------------------------------------------
// dllp_checker: port-level checks for the linked-list node pool
// Watches both channels of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module dllp_checker import dllp_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     req_valid,
    input logic                     req_ready,
    input logic                     rsp_valid,
    input logic                     rsp_ready,
    input logic [STATUS_W-1:0]      rsp_status,
    input logic [PTR_W-1:0]         rsp_new_handle,
    input logic signed [DATA_W-1:0] rsp_taken_value,
    input logic [CNT_W-1:0]         rsp_count
);

    // A waiting result holds until it is taken.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_count))
        else $error("result changed while stalled");

    // Items are worked one at a time: the command side is busy after an accept.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("command accepted while previous item in progress");

    // A rejected command (any status other than ok) reports no handle and no value.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != ST_OK |-> rsp_new_handle == '0 && rsp_taken_value == '0)
        else $error("failed command carries payload");

    // A full pool means every node is in the list.
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == ST_FULL |-> rsp_count == CNT_W'(POOL_DEPTH))
        else $error("pool full reported with free nodes");

    // An empty report comes only from an empty list.
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == ST_EMPTY |-> rsp_count == '0)
        else $error("list empty reported with nodes present");

endmodule

bind doubly_linked_list_pool_core dllp_checker u_dllp_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_new_handle  (rsp.new_handle),
    .rsp_taken_value (rsp.taken_value),
    .rsp_count       (rsp.count)
);

// File: test/tb_doubly_linked_list_pool_core.sv
// ----------------------------------------------------------------------------
// tb_doubly_linked_list_pool_core: self-checking bench for the node pool list
// Drives push, pop and remove commands through the command channel, keeps
// its own copy of the list, links and free stack to predict every result
// item, and compares each result field by field. Both channels idle at
// random.
// ----------------------------------------------------------------------------
module tb_doubly_linked_list_pool_core;
    import dllp_pkg::*;

    // Command codes past the last defined one. The block must answer them
    // with an ok status and leave the list alone.
    localparam logic [CMD_W-1:0] CMD_RESERVED_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RESERVED_LAST  = 3'd7;

    localparam int RANDOM_ITEMS   = 1100;
    // Neither side's longest gap nor a command's run through the block comes near
    // this limit, so it leaves a wide margin over a correct run.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 10;
    localparam int REPORT_LIMIT   = 10;

    // Bias of one stretch of random stimulus: fill the pool, empty it, or
    // keep the length wandering around the middle.
    typedef enum int {
        MIX_GROW,
        MIX_DRAIN,
        MIX_CHURN
    } mix_t;

    // One expected result item, with the widths of the result channel.
    typedef struct packed {
        status_t                  status;
        logic [PTR_W-1:0]         new_handle;
        logic signed [DATA_W-1:0] taken_value;
        logic [CNT_W-1:0]         count;
    } outcome_t;

    // ------------------------------------------------------------------------
    // List pool tracker: mirrors the node pool and queues expected results.
    // ------------------------------------------------------------------------
    class list_pool_tracker;
        logic signed [DATA_W-1:0] node_value [POOL_DEPTH];
        logic [LINK_W-1:0]        prev_link  [POOL_DEPTH];
        logic [LINK_W-1:0]        next_link  [POOL_DEPTH];
        bit                       live       [POOL_DEPTH];
        logic [PTR_W-1:0]         free_slot  [POOL_DEPTH];
        int                       free_top;
        logic [LINK_W-1:0]        head;
        logic [LINK_W-1:0]        tail;
        int                       length;
        outcome_t                 awaited [$];
        int                       mismatches;

        function new();
            for (int i = 0; i < POOL_DEPTH; i++)
            begin
                live[i]      = 1'b0;
                node_value[i] = '0;
                prev_link[i] = NIL;
                next_link[i] = NIL;
                // Index 0 sits on top of the stack and is handed out first.
                free_slot[i] = PTR_W'(POOL_DEPTH - 1 - i);
            end
            free_top   = POOL_DEPTH;
            head       = NIL;
            tail       = NIL;
            length     = 0;
            mismatches = 0;
        endfunction

        function logic signed [DATA_W-1:0] unlink(logic [PTR_W-1:0] n);
            logic [LINK_W-1:0] p;
            logic [LINK_W-1:0] q;
            p = prev_link[n];
            q = next_link[n];
            if (p != NIL)
                next_link[p[PTR_W-1:0]] = q;
            else
                head = q;
            if (q != NIL)
                prev_link[q[PTR_W-1:0]] = p;
            else
                tail = p;
            live[n] = 1'b0;
            if (free_top < POOL_DEPTH)
            begin
                free_slot[free_top] = n;
                free_top++;
            end
            length--;
            return node_value[n];
        endfunction

        // Works out the result of one accepted command and queues it.
        function void note_command(logic [CMD_W-1:0] op, logic signed [DATA_W-1:0] val,
                                   logic [PTR_W-1:0] h);
            outcome_t         res;
            logic [PTR_W-1:0] n;
            logic [LINK_W-1:0] end_link;
            res = '{status: ST_OK, new_handle: '0, taken_value: '0, count: '0};
            case (op)
                CMD_PUSH_FRONT, CMD_PUSH_BACK:
                begin
                    if (free_top == 0)
                        res.status = ST_FULL;
                    else
                    begin
                        free_top--;
                        n = free_slot[free_top];
                        node_value[n] = val;
                        prev_link[n]  = NIL;
                        next_link[n]  = NIL;
                        live[n]       = 1'b1;
                        length++;
                        if (head == NIL)
                        begin
                            head = LINK_W'(n);
                            tail = LINK_W'(n);
                        end
                        else if (op == CMD_PUSH_FRONT)
                        begin
                            next_link[n] = head;
                            prev_link[head[PTR_W-1:0]] = LINK_W'(n);
                            head = LINK_W'(n);
                        end
                        else
                        begin
                            prev_link[n] = tail;
                            next_link[tail[PTR_W-1:0]] = LINK_W'(n);
                            tail = LINK_W'(n);
                        end
                        res.new_handle = n;
                    end
                end
                CMD_POP_FRONT, CMD_POP_BACK:
                begin
                    end_link = (op == CMD_POP_FRONT) ? head : tail;
                    if (end_link == NIL || !live[end_link[PTR_W-1:0]])
                        res.status = ST_EMPTY;
                    else
                        res.taken_value = unlink(end_link[PTR_W-1:0]);
                end
                CMD_REMOVE:
                begin
                    if (!live[h])
                        res.status = ST_BAD_HANDLE;
                    else
                        res.taken_value = unlink(h);
                end
                default:
                begin
                end
            endcase
            res.count = CNT_W'(length);
            awaited.push_back(res);
        endfunction

        // Compares one accepted result item with the oldest expectation.
        function void check_result(logic [STATUS_W-1:0] st, logic [PTR_W-1:0] nh,
                                   logic signed [DATA_W-1:0] tv, logic [CNT_W-1:0] cnt);
            outcome_t exp_res;
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result item: status %0d handle %0d value %0d count %0d",
                             st, nh, tv, cnt);
                return;
            end
            exp_res = awaited.pop_front();
            if (exp_res.status !== st || exp_res.new_handle !== nh ||
                exp_res.taken_value !== tv || exp_res.count !== cnt)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"result mismatch: expected status %0d handle %0d value %0d ",
                              "count %0d, got status %0d handle %0d value %0d count %0d"},
                             exp_res.status, exp_res.new_handle, exp_res.taken_value,
                             exp_res.count, st, nh, tv, cnt);
            end
        endfunction

        // Any handle currently on the list, or the fallback when it is empty.
        function logic [PTR_W-1:0] pick_live_handle(logic [PTR_W-1:0] fallback);
            logic [PTR_W-1:0] ids [$];
            for (int i = 0; i < POOL_DEPTH; i++)
                if (live[i])
                    ids.push_back(PTR_W'(i));
            if (ids.size() == 0)
                return fallback;
            return ids[$urandom_range(0, ids.size() - 1)];
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    dllp_req_if req_ch ();
    dllp_rsp_if rsp_ch ();

    doubly_linked_list_pool_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    list_pool_tracker pool_model;
    int               idle_cycles = 0;
    // While set, neither side inserts gaps, so the block runs back to back.
    bit               no_idle;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Gap length in cycles: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Presents one command item after a random gap and holds it until the
    // block takes it. Valid stays high when the next item follows at once,
    // so it is never lowered and raised at the same edge.
    task automatic send_command(input logic [CMD_W-1:0] op,
                                input logic signed [DATA_W-1:0] val,
                                input logic [PTR_W-1:0] h);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
        end
        @(negedge clk);
        req_ch.valid       <= 1'b1;
        req_ch.cmd         <= op;
        req_ch.value       <= val;
        req_ch.node_handle <= h;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    // One random command shaped by the current mix. Most removes name a node
    // that is on the list so that unlinking in the middle is exercised; the
    // rest name any handle. Reserved codes do not count as real items.
    task automatic random_command(input mix_t mix, output int counted);
        int                       roll;
        int                       push_pct;
        logic [CMD_W-1:0]         op;
        logic signed [DATA_W-1:0] val;
        logic [PTR_W-1:0]         h;
        roll     = $urandom_range(0, 99);
        push_pct = (mix == MIX_GROW) ? 80 : (mix == MIX_DRAIN) ? 15 : 48;
        h        = PTR_W'($urandom_range(0, POOL_DEPTH - 1));
        case ($urandom_range(0, 19))
            0:       val = 32'sh7fff_ffff;
            1:       val = 32'sh8000_0000;
            2:       val = '0;
            3:       val = -32'sd1;
            default: val = $urandom;
        endcase
        counted = 1;
        if (roll < 3)
        begin
            op      = CMD_W'($urandom_range(CMD_RESERVED_FIRST, CMD_RESERVED_LAST));
            counted = 0;
        end
        else if (roll < 3 + push_pct)
            op = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
        else
        begin
            case ($urandom_range(0, 2))
                0:       op = CMD_POP_FRONT;
                1:       op = CMD_POP_BACK;
                default: op = CMD_REMOVE;
            endcase
            if (op == CMD_REMOVE && $urandom_range(0, 4) != 0)
                h = pool_model.pick_live_handle(h);
        end
        send_command(op, val, h);
    endtask

    // Result side: ready toggles between random stalls and random bursts.
    initial
    begin
        int stall;
        int burst;
        rsp_ch.ready = 1'b0;
        forever
        begin
            stall = pick_gap();
            repeat (stall)
            begin
                @(negedge clk);
                rsp_ch.ready <= 1'b0;
            end
            burst = $urandom_range(1, 8);
            repeat (burst)
            begin
                @(negedge clk);
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Both channels are watched at the rising edge. Inputs only move at the
    // falling edge, so the values seen here are the ones the block sampled.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
                pool_model.note_command(req_ch.cmd, req_ch.value, req_ch.node_handle);
            if (rsp_ch.valid && rsp_ch.ready)
                pool_model.check_result(rsp_ch.status, rsp_ch.new_handle,
                                        rsp_ch.taken_value, rsp_ch.count);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // A hang shows up as a long run of cycles in which neither side moves.
    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("doubly_linked_list_pool_core regression: fail");
        $finish;
    end

    initial
    begin
        int   sent;
        int   counted;
        int   span;
        bit   first_phase;
        mix_t mix;

        pool_model         = new();
        no_idle            = 1'b0;
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.cmd         = CMD_PUSH_FRONT;
        req_ch.value       = '0;
        req_ch.node_handle = '0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. On an empty pool, pops report empty and removes of
        // either end of the handle range report an invalid handle.
        send_command(CMD_POP_FRONT, '0, '0);
        send_command(CMD_POP_BACK, '0, '0);
        send_command(CMD_REMOVE, '0, '0);
        send_command(CMD_REMOVE, '0, 6'd63);
        send_command(CMD_RESERVED_FIRST, 32'sh1234_5678, 6'd63);
        // Pushes with the extreme values. Handles come off the free stack in
        // order, so the list becomes 2 0 1 3 4.
        send_command(CMD_PUSH_FRONT, 32'sh7fff_ffff, '0);
        send_command(CMD_PUSH_BACK, 32'sh8000_0000, '0);
        send_command(CMD_PUSH_FRONT, '0, '0);
        send_command(CMD_PUSH_BACK, -32'sd1, '0);
        send_command(CMD_PUSH_BACK, 32'sh5555_5555, 6'd63);
        send_command(CMD_RESERVED_LAST, -32'sd1, 6'd21);
        // Unlink in the middle, at the head and at the tail by handle.
        send_command(CMD_REMOVE, '0, 6'd1);
        send_command(CMD_REMOVE, '0, 6'd2);
        send_command(CMD_REMOVE, '0, 6'd4);
        // A handle that was just freed is no longer valid.
        send_command(CMD_REMOVE, '0, 6'd1);
        send_command(CMD_POP_FRONT, '0, '0);
        send_command(CMD_POP_BACK, '0, '0);
        // A lone node is both head and tail; removing it empties the list.
        // The last node freed, handle 3, is the next one handed out.
        send_command(CMD_PUSH_BACK, 32'sh2aaa_aaaa, '0);
        send_command(CMD_REMOVE, '0, 6'd3);
        send_command(CMD_POP_BACK, '0, '0);
        send_command(CMD_POP_FRONT, '0, '0);

        // Random part in stretches of one mix each. The first stretch is
        // biased hard enough to fill the pool and run into the full case.
        sent        = 0;
        first_phase = 1'b1;
        while (sent < RANDOM_ITEMS)
        begin
            mix         = first_phase ? MIX_GROW : mix_t'($urandom_range(0, 2));
            span        = first_phase ? 120 : $urandom_range(40, 160);
            no_idle     = ($urandom_range(0, 4) == 0);
            first_phase = 1'b0;
            repeat (span)
            begin
                if (sent < RANDOM_ITEMS)
                begin
                    random_command(mix, counted);
                    sent += counted;
                end
            end
        end
        no_idle = 1'b0;

        @(negedge clk);
        req_ch.valid <= 1'b0;

        while (pool_model.awaited.size() != 0)
            @(posedge clk);
        // Give a stray extra result the chance to show up.
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (pool_model.awaited.size() != 0)
            pool_model.mismatches++;
        if (pool_model.mismatches == 0)
            $display("doubly_linked_list_pool_core regression: pass");
        else
            $display("doubly_linked_list_pool_core regression: fail");
        $finish;
    end

endmodule
